// ===== rtl/core/sabs_pkg.sv =====
// ----------------------------------------------------------------------------
// sabs_pkg: shared types and constants for the sort and search block
// Request and status codes, the front-to-back command word and default sizes.
// ----------------------------------------------------------------------------
package sabs_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int DATA_W       = 32;
    localparam int RIDX_W       = 7;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_SEARCH = 2'd1;
    localparam logic [1:0] REQ_READ   = 2'd2;
    localparam logic [1:0] REQ_BAD    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTREADY = 2'd3;

    typedef struct packed {
        logic [1:0]        req;
        logic signed [31:0] data;
        logic [6:0]        ridx;
        logic              last;
    } cmd_t;

endpackage

// ===== rtl/core/sort_and_binary_search_top.sv =====
// ----------------------------------------------------------------------------
// sort_and_binary_search_top: sorted element store with binary search
// Request stream in, one result transfer out per request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries requests: load, search or read. A load marked by tlast
//   closes the set and starts an in-place selection sort of more than one element.
//   m_axis returns one result per request: status, index and value.
//   Steps: a load is written from S_IDLE, a read passes S_RD and S_RDW, a
//   search runs one S_SRCH, S_SCMP pair per probe and a final S_SRCH when
//   the key is not found. After a last load the sort makes one pass per
//   position through S_RDI, S_SCANW and S_SCAN, scanning with the single RAM
//   read port, then swaps in S_SWP1 and S_SWP2. The back end works on one
//   request at a time and takes the next one in the cycle its result leaves.
//   A two-entry queue lets requests be taken while the back end works.
//   The result register holds while m_axis_tready is low; the back end
//   takes no new request until the held result has gone.
//   Reset clears the element count and the ready flag; no clearing pass.
// ----------------------------------------------------------------------------
module sort_and_binary_search_top
#(
    parameter int CAPACITY = sabs_pkg::DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // data_value[31:0], read_index[38:32], zero
    input  logic [1:0]  s_axis_tuser,  // req_type
    input  logic        s_axis_tlast,  // last_load
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // status[1:0], result_index[8:2], result_value[40:9]
);

    sabs_pkg::cmd_t  s_cmd, q_cmd;
    logic            q_valid, q_pop;
    logic [1:0]      st;
    logic [6:0]      ri;
    logic signed [31:0] rv;

    assign s_cmd.req  = s_axis_tuser;
    assign s_cmd.data = s_axis_tdata[31:0];
    assign s_cmd.ridx = s_axis_tdata[38:32];
    assign s_cmd.last = s_axis_tlast;
    assign m_axis_tdata = {7'd0, rv, ri, st};

    sabs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_cmd    (s_cmd),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd)
    );

    sabs_back #(.CAPACITY(CAPACITY)) u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_cmd        (q_cmd),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .status       (st),
        .result_index (ri),
        .result_value (rv)
    );

endmodule

// ===== rtl/core/sabs_front.sv =====
// ----------------------------------------------------------------------------
// sabs_front: input side
// Accepts request transfers and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sabs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  sabs_pkg::cmd_t   s_cmd,
    output logic             q_valid,
    input  logic             q_pop,
    output sabs_pkg::cmd_t   q_cmd
);

    sabs_pkg::cmd_t q_mem_reg [2];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wp_reg] <= s_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/sabs_back.sv =====
// ----------------------------------------------------------------------------
// sabs_back: execution side
// Stores elements, runs the selection sort and binary search over a local RAM.
// ----------------------------------------------------------------------------
module sabs_back
#(
    parameter int CAPACITY = sabs_pkg::DEF_CAPACITY
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  sabs_pkg::cmd_t      q_cmd,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          status,
    output logic [6:0]          result_index,
    output logic signed [31:0]  result_value
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDI   = 4'd1;  // read element i
    localparam logic [3:0] S_SCAN  = 4'd2;  // scan j for minimum
    localparam logic [3:0] S_SWP1  = 4'd3;
    localparam logic [3:0] S_SWP2  = 4'd4;
    localparam logic [3:0] S_SRCH  = 4'd5;  // issue probe
    localparam logic [3:0] S_SCMP  = 4'd6;  // compare probe
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_RDW   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_SCANW = 4'd10;

    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    logic [3:0]         state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic               ready_reg, ready_next;
    logic [CW-1:0]      i_reg, i_next, j_reg, j_next, best_reg, best_next;
    logic signed [31:0] vi_reg, vi_next, vbest_reg, vbest_next;
    logic signed [SW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic signed [SW-1:0] mid;
    logic signed [31:0] key_reg, key_next;
    logic [1:0]         st_reg, st_next;
    logic [6:0]         ri_reg, ri_next;
    logic signed [31:0] rv_reg, rv_next;
    logic               ov_reg, ov_next;

    assign mid          = (lo_reg + hi_reg) >>> 1;
    assign status       = st_reg;
    assign result_index = ri_reg;
    assign result_value = rv_reg;
    assign m_tvalid     = ov_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ready_next = ready_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        best_next  = best_reg;
        vi_next    = vi_reg;
        vbest_next = vbest_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        key_next   = key_reg;
        st_next    = st_reg;
        ri_next    = ri_reg;
        rv_next    = rv_reg;
        ov_next    = ov_reg && !m_tready;
        q_pop      = 1'b0;
        we         = 1'b0;
        waddr      = i_reg[AW-1:0];
        wdata      = vbest_reg;
        raddr      = j_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && !ov_next)
                begin
                    q_pop   = 1'b1;
                    st_next = sabs_pkg::ST_OK;
                    ri_next = '0;
                    rv_next = '0;
                    key_next = q_cmd.data;
                    state_next = S_OUT;
                    unique case (q_cmd.req)
                        sabs_pkg::REQ_LOAD:
                        begin
                            count_next = ready_reg ? '0 : count_reg;
                            ready_next = 1'b0;
                            if (count_next < CW'(CAPACITY))
                            begin
                                we         = 1'b1;
                                waddr      = count_next[AW-1:0];
                                wdata      = q_cmd.data;
                                ri_next    = 7'(count_next);
                                count_next = count_next + 1'b1;
                            end
                            else
                            begin
                                st_next = sabs_pkg::ST_RANGE;
                            end
                            if (q_cmd.last)
                            begin
                                ready_next = 1'b1;
                                i_next     = '0;
                                if (count_next > CW'(1))
                                begin
                                    state_next = S_RDI;
                                end
                            end
                        end
                        sabs_pkg::REQ_SEARCH:
                        begin
                            if (!ready_reg)
                            begin
                                st_next = sabs_pkg::ST_NOTREADY;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = SW'(count_reg) - 1'b1;
                                state_next = S_SRCH;
                            end
                        end
                        sabs_pkg::REQ_READ:
                        begin
                            if (!ready_reg)
                            begin
                                st_next = sabs_pkg::ST_NOTREADY;
                            end
                            else if (CW'(q_cmd.ridx) >= count_reg
                                     || 32'(q_cmd.ridx) >= CAPACITY)
                            begin
                                st_next = sabs_pkg::ST_RANGE;
                            end
                            else
                            begin
                                j_next     = CW'(q_cmd.ridx);
                                ri_next    = q_cmd.ridx;
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            st_next = sabs_pkg::ST_RANGE;
                        end
                    endcase
                end
            end
            S_RDI:
            begin
                raddr      = i_reg[AW-1:0];
                best_next  = i_reg;
                j_next     = i_reg + 1'b1;
                state_next = S_SCANW;
            end
            S_SCANW:
            begin
                vi_next    = rdata_reg;
                vbest_next = rdata_reg;
                raddr      = j_reg[AW-1:0];
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // rdata holds element j
                if (rdata_reg < vbest_reg)
                begin
                    vbest_next = rdata_reg;
                    best_next  = j_reg;
                end
                if (j_reg + 1'b1 < count_reg)
                begin
                    j_next = j_reg + 1'b1;
                    raddr  = j_next[AW-1:0];
                end
                else
                begin
                    state_next = S_SWP1;
                end
            end
            S_SWP1:
            begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = vbest_reg;
                state_next = S_SWP2;
            end
            S_SWP2:
            begin
                we     = 1'b1;
                waddr  = best_reg[AW-1:0];
                wdata  = vi_reg;
                i_next = i_reg + 1'b1;
                state_next = (i_next + 1'b1 < count_reg) ? S_RDI : S_OUT;
            end
            S_SRCH:
            begin
                if (lo_reg <= hi_reg)
                begin
                    raddr      = mid[AW-1:0];
                    state_next = S_SCMP;
                end
                else
                begin
                    st_next    = sabs_pkg::ST_NOTFOUND;
                    state_next = S_OUT;
                end
            end
            S_SCMP:
            begin
                if (rdata_reg == key_reg)
                begin
                    ri_next    = 7'(mid);
                    rv_next    = rdata_reg;
                    state_next = S_OUT;
                end
                else
                begin
                    if (rdata_reg < key_reg)
                    begin
                        lo_next = mid + 1'b1;
                    end
                    else
                    begin
                        hi_next = mid - 1'b1;
                    end
                    state_next = S_SRCH;
                end
            end
            S_RD:
            begin
                raddr      = j_reg[AW-1:0];
                state_next = S_RDW;
            end
            S_RDW:
            begin
                rv_next    = rdata_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        best_reg  <= best_next;
        vi_reg    <= vi_next;
        vbest_reg <= vbest_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        key_reg   <= key_next;
        st_reg    <= st_next;
        ri_reg    <= ri_next;
        rv_reg    <= rv_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ready_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
